// ===== sv/gated_loop_recorder_assert.svh =====
// Assertion macros for the gated loop recorder; empty when SYNTHESIS is defined.
`ifndef GATED_LOOP_RECORDER_ASSERT_SVH
`define GATED_LOOP_RECORDER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define GLR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gated_loop_recorder: assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define GLR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gated_loop_recorder: assertion failed");
`else
`define GLR_ASSERT_IMP(name, ante, cons)
`define GLR_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== sv/glr_pkg.sv =====
// Shared types and constants of the gated loop recorder.
package glr_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W   = 3;
  localparam int LEVEL_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Default sizes
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // Queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LINK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ARM    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REWIND = 3'd5;

  // Register map (word index)
  localparam logic REG_THRESH = 1'b0;
  localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'h8000;

  // Classified command from the front end
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             link_low;
  } cmd_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic mod_start;
    logic mod_wait;
  } bk_stat_t;

endpackage

// ===== sv/glr_fifo.sv =====
// Small flop-based FIFO used between front and back and on the result side.
module glr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];
  assign count   = fill;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== sv/glr_front.sv =====
// Front end: threshold register on the APB port and request classification.
module glr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glr_pkg::ADDR_W-1:0]  paddr,
  input  logic [glr_pkg::DATA_W-1:0]  pwdata,
  output logic [glr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic [glr_pkg::REQ_W-1:0]   req_type,
  input  logic [glr_pkg::LEVEL_W-1:0] link_level,
  output glr_pkg::cmd_t               cmd
);

  logic [glr_pkg::LEVEL_W-1:0] link_threshold;
  logic                        sel_thresh;

  assign pready     = 1'b1;
  assign sel_thresh = (paddr[2] == glr_pkg::REG_THRESH);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_threshold <= glr_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && sel_thresh) begin
      link_threshold <= pwdata[glr_pkg::LEVEL_W-1:0];
    end
  end

  // read-back
  always_comb begin
    prdata = '0;
    if (sel_thresh) begin
      prdata = glr_pkg::DATA_W'(link_threshold);
    end
  end

  // classify: carry the request code and the gate decision
  always_comb begin
    cmd.req      = req_type;
    cmd.link_low = (link_level < link_threshold);
  end

endmodule

// ===== sv/glr_mod.sv =====
// Iterative remainder unit: position modulo count, one bit per cycle.
module glr_mod #(
  parameter int STORE_DEPTH = glr_pkg::STORE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [$clog2(STORE_DEPTH)-1:0]     dividend,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]   divisor,
  output logic [$clog2(STORE_DEPTH)-1:0]     rem,
  output logic                               done
);

  localparam int POS_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH+1);
  localparam int STEP_W = $clog2(POS_W+1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [POS_W-1:0]  dvd;
  logic [CNT_W-1:0]  part;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {part, dvd[POS_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign rem   = part[POS_W-1:0];

  // restoring remainder, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= STEP_W'(POS_W);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      part <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, divisor}) begin
        part <= diff[CNT_W-1:0];
      end else begin
        part <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== sv/glr_back.sv =====
// Back end: recorder state, remainder unit, sample store, result stage and result queue.
module glr_back #(
  parameter int STORE_DEPTH = glr_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = glr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  glr_pkg::cmd_t                      head_cmd,
  input  logic [SAMPLE_BITS-1:0]             head_sample,
  output logic                               take,
  input  logic                               pop,
  output logic                               empty,
  output logic [SAMPLE_BITS-1:0]             out_value,
  output logic                               is_recording,
  output logic                               is_playing,
  output logic                               is_armed,
  output logic [$clog2(STORE_DEPTH)-1:0]     play_position,
  output logic [$clog2(STORE_DEPTH+1)-1:0]   stored_count,
  output logic                               sample_dropped,
  output glr_pkg::bk_stat_t                  stat
);

  localparam int POS_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH+1);
  localparam int EW     = POS_W + 1;
  localparam int RES_W  = SAMPLE_BITS + 3 + POS_W + CNT_W + 1;
  localparam int OCNT_W = $clog2(glr_pkg::OUT_DEPTH+1);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_MOD = 1'b1;

  // execute-stage state
  logic             state;
  logic             state_next;
  logic             rec;
  logic             rec_next;
  logic             play;
  logic             play_next;
  logic             armed;
  logic             armed_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // execute-stage controls
  logic             credit;
  logic             is_tick;
  logic             needs_mod;
  logic             in_mod;
  logic             exec;
  logic             mod_start;
  logic             mod_done;
  logic [POS_W-1:0] mod_rem;
  logic [POS_W-1:0] idx;
  logic             mem_we;
  logic             mem_re;
  logic [POS_W-1:0] mem_addr;
  logic             drop;
  logic             ld_mem;
  logic             ld_smp;

  // store
  logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;

  // result stage
  logic                   b_valid;
  logic                   b_ld_mem;
  logic                   b_ld_smp;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic                   b_rec;
  logic                   b_play;
  logic                   b_armed;
  logic [POS_W-1:0]       b_pos;
  logic [CNT_W-1:0]       b_cnt;
  logic                   b_drop;
  logic [SAMPLE_BITS-1:0] held;
  logic [SAMPLE_BITS-1:0] held_next;

  // result queue
  logic [RES_W-1:0]  res_in;
  logic [RES_W-1:0]  res_out;
  logic [OCNT_W-1:0] out_count;
  logic              out_full;

  // issue only when the result queue can absorb everything in flight
  assign credit = (out_count + OCNT_W'(b_valid)) < OCNT_W'(glr_pkg::OUT_DEPTH);

  // a playback tick at or beyond the count needs the remainder unit first
  assign is_tick   = (head_cmd.req == glr_pkg::REQ_TICK);
  assign needs_mod = is_tick && !rec && play && (cnt != '0) && (EW'(pos) >= EW'(cnt));
  assign in_mod    = (state == ST_MOD);
  assign exec      = head_valid && credit && (in_mod ? mod_done : !needs_mod);
  assign mod_start = !in_mod && head_valid && credit && needs_mod;
  assign take      = exec;
  assign idx       = in_mod ? mod_rem : pos;
  assign mem_addr  = mem_we ? cnt[POS_W-1:0] : idx;

  assign stat.mod_start = mod_start;
  assign stat.mod_wait  = in_mod;

  glr_mod #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (pos),
    .divisor  (cnt),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  // wait state around the remainder unit
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (mod_start) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (exec) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // request execution
  always_comb begin
    rec_next   = rec;
    play_next  = play;
    armed_next = armed;
    pos_next   = pos;
    cnt_next   = cnt;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    drop       = 1'b0;
    ld_mem     = 1'b0;
    ld_smp     = 1'b0;
    if (exec) begin
      case (head_cmd.req)
        glr_pkg::REQ_TICK: begin
          if (rec) begin
            if (head_cmd.link_low) begin
              rec_next = 1'b0;
            end else begin
              ld_smp = 1'b1;
              if (cnt < CNT_W'(STORE_DEPTH)) begin
                mem_we   = 1'b1;
                cnt_next = cnt + 1'b1;
              end else begin
                drop = 1'b1;
              end
            end
          end else if (play && (cnt != '0)) begin
            mem_re = 1'b1;
            ld_mem = 1'b1;
            if ((EW'(pos) + 1'b1 >= EW'(cnt)) || head_cmd.link_low) begin
              play_next = 1'b0;
              pos_next  = '0;
            end else begin
              pos_next = pos + 1'b1;
            end
          end
        end
        glr_pkg::REQ_LINK: begin
          rec_next  = 1'b0;
          pos_next  = '0;
          play_next = 1'b1;
          if (armed) begin
            armed_next = 1'b0;
            cnt_next   = '0;
            rec_next   = 1'b1;
          end
        end
        glr_pkg::REQ_ARM: begin
          armed_next = !armed;
        end
        glr_pkg::REQ_START: begin
          cnt_next = '0;
          rec_next = 1'b1;
        end
        glr_pkg::REQ_STOP: begin
          rec_next = 1'b0;
        end
        glr_pkg::REQ_REWIND: begin
          pos_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // execute-stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      rec   <= 1'b0;
      play  <= 1'b0;
      armed <= 1'b0;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      rec   <= rec_next;
      play  <= play_next;
      armed <= armed_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
    end
  end

  // sample store, one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= head_sample;
    end
    if (mem_re) begin
      rd_data <= store[mem_addr];
    end
  end

  // result stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      b_ld_mem <= ld_mem;
      b_ld_smp <= ld_smp;
      b_sample <= head_sample;
      b_rec    <= rec_next;
      b_play   <= play_next;
      b_armed  <= armed_next;
      b_pos    <= pos_next;
      b_cnt    <= cnt_next;
      b_drop   <= drop;
    end
  end

  // held output follows the store on playback, the input while recording
  always_comb begin
    held_next = held;
    if (b_valid && b_ld_mem) begin
      held_next = rd_data;
    end else if (b_valid && b_ld_smp) begin
      held_next = b_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

  assign res_in = {held_next, b_rec, b_play, b_armed, b_pos, b_cnt, b_drop};

  glr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (glr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .pop   (pop),
    .wdata (res_in),
    .rdata (res_out),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  // result word unpack; the full flag never stops a push because of the credit check
  always_comb begin
    {out_value, is_recording, is_playing, is_armed,
     play_position, stored_count, sample_dropped} = res_out;
    if (out_full && b_valid) begin
      sample_dropped = res_out[0];
    end
  end

endmodule

// ===== sv/gated_loop_recorder.sv =====
// Top level of the gated loop recorder: front end, command queue and back end.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | push / full          | req_type, link_level, sample_value
//  result    | pop / empty          | out_value, is_recording, is_playing,
//            |                      | is_armed, play_position, stored_count,
//            |                      | sample_dropped
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One word per cycle in and out unless a tick waits on the remainder unit or
// the result side stalls. A word passes the command queue, result stage and
// result queue from push to the result port. A playback tick at or past the
// stored count waits for the bit-serial remainder unit. rst is synchronous and
// clears all flags, counts and queues; the store is not cleared. A stalled
// result side fills the four-word result and command queues before full rises.
module gated_loop_recorder #(
  parameter int STORE_DEPTH = glr_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = glr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [glr_pkg::ADDR_W-1:0]         paddr,
  input  logic [glr_pkg::DATA_W-1:0]         pwdata,
  output logic [glr_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // request side
  input  logic                               push,
  output logic                               full,
  input  logic [glr_pkg::REQ_W-1:0]          req_type,
  input  logic [glr_pkg::LEVEL_W-1:0]        link_level,
  input  logic [SAMPLE_BITS-1:0]             sample_value,
  // result side
  input  logic                               pop,
  output logic                               empty,
  output logic [SAMPLE_BITS-1:0]             out_value,
  output logic                               is_recording,
  output logic                               is_playing,
  output logic                               is_armed,
  output logic [$clog2(STORE_DEPTH)-1:0]     play_position,
  output logic [$clog2(STORE_DEPTH+1)-1:0]   stored_count,
  output logic                               sample_dropped
);

`include "gated_loop_recorder_assert.svh"

  localparam int CMD_W = $bits(glr_pkg::cmd_t);
  localparam int MID_W = SAMPLE_BITS + CMD_W;
  localparam int CNT_W = $clog2(STORE_DEPTH+1);
  localparam int MCNT_W = $clog2(glr_pkg::MID_DEPTH+1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STORE_DEPTH);

  glr_pkg::cmd_t          cmd;
  glr_pkg::cmd_t          head_cmd;
  glr_pkg::bk_stat_t      stat;
  logic [MID_W-1:0]       mid_in;
  logic [MID_W-1:0]       mid_out;
  logic [SAMPLE_BITS-1:0] head_sample;
  logic                   mid_empty;
  logic                   take;
  logic [MCNT_W-1:0]      mid_count;

  glr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_type   (req_type),
    .link_level (link_level),
    .cmd        (cmd)
  );

  assign mid_in = {sample_value, cmd};

  // command queue between classification and execution
  glr_fifo #(
    .WIDTH (MID_W),
    .DEPTH (glr_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (take),
    .wdata (mid_in),
    .rdata (mid_out),
    .full  (full),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign {head_sample, head_cmd} = mid_out;

  glr_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (!mid_empty),
    .head_cmd       (head_cmd),
    .head_sample    (head_sample),
    .take           (take),
    .pop            (pop),
    .empty          (empty),
    .out_value      (out_value),
    .is_recording   (is_recording),
    .is_playing     (is_playing),
    .is_armed       (is_armed),
    .play_position  (play_position),
    .stored_count   (stored_count),
    .sample_dropped (sample_dropped),
    .stat           (stat)
  );

  // checks
  `GLR_ASSERT_IMP(a_count_bound, !empty, stored_count <= CNT_MAX)
  `GLR_ASSERT_IMP(a_drop_full, !empty && sample_dropped, is_recording && (stored_count == CNT_MAX))
  `GLR_ASSERT_NXT(a_mod_wait, stat.mod_start, stat.mod_wait && (mid_count != '0))

endmodule
